// File: src/prs80_pkg.sv
// Shared types, constants and round functions for the PRESENT-80 encrypt core.
// No dependencies; imported by every module of the core.
`default_nettype none

package prs80_pkg;

    localparam int BLK_W = 64;
    localparam int KEY_W = 80;
    localparam int RND_W = 5;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;

    typedef logic [BLK_W-1:0] t_block;
    typedef logic [KEY_W-1:0] t_key;
    typedef logic [RND_W-1:0] t_rnd;

    // Handshake control between a stage and the pipeline controller.
    typedef struct packed {
        logic adv;
        logic valid;
    } t_stage_ctl;

    // The 4-bit PRESENT substitution box.
    function automatic logic [3:0] sbox(input logic [3:0] x);
        logic [3:0] y;
        case (x)
            4'h0: y = 4'hc;
            4'h1: y = 4'h5;
            4'h2: y = 4'h6;
            4'h3: y = 4'hb;
            4'h4: y = 4'h9;
            4'h5: y = 4'h0;
            4'h6: y = 4'ha;
            4'h7: y = 4'hd;
            4'h8: y = 4'h3;
            4'h9: y = 4'he;
            4'ha: y = 4'hf;
            4'hb: y = 4'h8;
            4'hc: y = 4'h4;
            4'hd: y = 4'h7;
            4'he: y = 4'h1;
            4'hf: y = 4'h2;
            default: y = 4'h0;
        endcase
        return y;
    endfunction

    // S-box layer over all sixteen nibbles.
    function automatic t_block sub_nibbles(input t_block s);
        t_block r;
        for (int n = 0; n < 16; n++) begin
            r[4*n +: 4] = sbox(s[4*n +: 4]);
        end
        return r;
    endfunction

    // Bit permutation: bit b moves to 16*(b mod 4) + b/4, which is the
    // 6-bit index with its two low bits rotated to the top; bit 63 stays.
    function automatic t_block perm_bits(input t_block s);
        t_block r;
        logic [5:0] src;
        r = '0;
        for (int b = 0; b < BLK_W; b++) begin
            src = 6'(b);
            r[{src[1:0], src[5:2]}] = s[b];
        end
        return r;
    endfunction

    // Key schedule step: rotate left by 61, S-box on the top nibble,
    // round counter into bits 19..15.
    function automatic t_key key_update(input t_key k, input t_rnd rnd);
        t_key r;
        r = {k[18:0], k[79:19]};
        r[79:76] = sbox(r[79:76]);
        r[19:15] = r[19:15] ^ rnd;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/prs80_round.sv
// One PRESENT round as a pipeline stage: round key add, S-box layer,
// permutation and key schedule step. Depends on prs80_pkg.
`default_nettype none

module prs80_round
    import prs80_pkg::*;
#(
    parameter logic [4:0] RND = 5'd1
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire t_stage_ctl i_ctl,
    input  wire t_block     i_state,
    input  wire t_key       i_key,
    output logic            o_valid,
    output t_block          o_state,
    output t_key            o_key
);

    logic   r_valid;
    t_block r_state;
    t_key   r_key;
    t_block n_state;
    t_key   n_key;

    // Round datapath.
    always_comb begin
        n_state = perm_bits(sub_nibbles(i_state ^ i_key[79:16]));
        n_key   = key_update(i_key, RND);
    end

    // Valid bit is reset; payload loads whenever the pipeline advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.adv) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_state <= n_state;
            r_key   <= n_key;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_key   = r_key;

endmodule

`default_nettype wire

// File: src/prs80_keyreg.sv
// Configuration registers holding the 80-bit cipher key.
// Depends on prs80_pkg.
`default_nettype none

module prs80_keyreg
    import prs80_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire [CFG_IDX_W-1:0] i_cfg_index,
    input  wire [63:0]          i_cfg_data,
    output t_key                o_key
);

    logic [63:0] r_key_low;
    logic [15:0] r_key_high;

    assign o_cfg_ready = 1'b1;

    // Register writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                CFG_KEY_HIGH: r_key_high <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_key = {r_key_high, r_key_low};

endmodule

`default_nettype wire

// File: src/present80_block_encrypt_core.sv
// PRESENT-80 encryption, one round per pipeline stage, one block a cycle unless the output stalls.
// Uses the round stages, the key registers and prs80_pkg.
//
// The core accepts one 64-bit block every clock cycle while the output is
// not stalled, and carries each through one register stage per round,
// then the output register with the final key add. Every stage carries its
// own copy of the key schedule, so blocks in flight never interfere. The
// whole pipeline moves on one enable taken from the output register: while
// a finished block waits on o_m_tvalid with i_m_tready low, the pipeline
// holds and o_s_tready is low; with the output free or being taken, a new
// block enters every cycle. The user must write the key through the
// configuration channel only while no block is in flight; the core does
// not enforce this. There is no clearing pass after reset.
`default_nettype none

module present80_block_encrypt_core
    import prs80_pkg::*;
#(
    parameter int ROUNDS = 31
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // Configuration channel.
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire [CFG_IDX_W-1:0] i_cfg_index,
    input  wire [63:0]          i_cfg_data,
    // Slave stream: tdata = plaintext[63:0].
    input  wire                 i_s_tvalid,
    output logic                o_s_tready,
    input  wire [63:0]          i_s_tdata,
    // Master stream: tdata = ciphertext[63:0].
    output logic                o_m_tvalid,
    input  wire                 i_m_tready,
    output logic [63:0]         o_m_tdata
);

    t_key          w_cfg_key;
    logic          w_adv;
    logic [ROUNDS:0] w_valid;
    t_block        w_state [ROUNDS+1];
    t_key          w_key   [ROUNDS+1];
    logic          r_out_valid;
    t_block        r_out_data;
    t_block        n_out_data;

    // Key registers.
    prs80_keyreg u_keyreg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_key       (w_cfg_key)
    );

    // Global advance: the output register is free or being drained.
    assign w_adv      = !r_out_valid || i_m_tready;
    assign o_s_tready = w_adv;

    assign w_valid[0] = i_s_tvalid;
    assign w_state[0] = i_s_tdata;
    assign w_key[0]   = w_cfg_key;

    // Round stages.
    for (genvar g = 0; g < ROUNDS; g++) begin : g_round
        t_stage_ctl w_ctl;
        assign w_ctl.adv   = w_adv;
        assign w_ctl.valid = w_valid[g];

        prs80_round #(
            .RND (5'(g + 1))
        ) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_state (w_state[g]),
            .i_key   (w_key[g]),
            .o_valid (w_valid[g+1]),
            .o_state (w_state[g+1]),
            .o_key   (w_key[g+1])
        );
    end

    // Final round key add into the output register.
    assign n_out_data = w_state[ROUNDS] ^ w_key[ROUNDS][79:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_valid[ROUNDS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // An accepted request shows up as valid in the first round stage.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> w_valid[1])
        else $error("accepted block did not enter the first round stage");

    // A stalled output freezes the valid bit of every round stage.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(w_valid[ROUNDS:1]))
        else $error("pipeline moved while the output was stalled");

    // A new result only appears from a valid last round stage.
    a_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(w_valid[ROUNDS]))
        else $error("result appeared without a block in the last stage");

    // While stalled, no new request is taken.
    a_noaccept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("request accepted while the pipeline was stalled");

endmodule

`default_nettype wire

// File: tb/sv/prs80_cipher_checker.sv
// Checker for the PRESENT-80 encrypt core: watches the key, plaintext and
// ciphertext channels, predicts each ciphertext and compares in order.
// Depends on prs80_pkg for the configuration register indexes.

module prs80_cipher_checker
    import prs80_pkg::*;
#(
    parameter int ROUNDS = 31
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_valid,
    input  wire                 i_cfg_ready,
    input  wire [CFG_IDX_W-1:0] i_cfg_index,
    input  wire [63:0]          i_cfg_data,
    input  wire                 i_s_tvalid,
    input  wire                 i_s_tready,
    input  wire [63:0]          i_s_tdata,   // plaintext[63:0]
    input  wire                 i_m_tvalid,
    input  wire                 i_m_tready,
    input  wire [63:0]          i_m_tdata,   // ciphertext[63:0]
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // The PRESENT S-box, entry n in bits 4n+3..4n.
    localparam logic [63:0] SBOX_NIBBLES = 64'h21748fe3da09b65c;

    logic [79:0] cipher_key;
    logic [63:0] expected_ct[$];
    logic [63:0] want_ct;
    int          fail_cnt = 0;

    function automatic logic [3:0] sbox_lookup(input logic [3:0] x);
        return SBOX_NIBBLES[4*x +: 4];
    endfunction

    function automatic logic [63:0] sbox_layer(input logic [63:0] s);
        logic [63:0] r;
        for (int n = 0; n < 16; n++) begin
            r[4*n +: 4] = sbox_lookup(s[4*n +: 4]);
        end
        return r;
    endfunction

    // Bit b moves to 16*b mod 63; the top bit stays where it is.
    function automatic logic [63:0] p_layer(input logic [63:0] s);
        logic [63:0] r;
        r = '0;
        r[63] = s[63];
        for (int b = 0; b < 63; b++) begin
            r[(16 * b) % 63] = s[b];
        end
        return r;
    endfunction

    // Full encryption of one block; the key schedule restarts from the
    // configured key for every block.
    function automatic logic [63:0] present80_encrypt(input logic [63:0] pt,
                                                      input logic [79:0] key);
        logic [63:0] st;
        logic [79:0] k;
        st = pt;
        k = key;
        for (int rnd = 1; rnd <= ROUNDS; rnd++) begin
            st = p_layer(sbox_layer(st ^ k[79:16]));
            k = (k << 61) | (k >> 19);
            k[79:76] = sbox_lookup(k[79:76]);
            k[19:15] = k[19:15] ^ 5'(rnd);
        end
        return st ^ k[79:16];
    endfunction

    // All channels are sampled at the rising edge, before any update lands.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cipher_key = '0;
            expected_ct.delete();
        end else begin
            // Key writes; other indexes leave the key alone.
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_KEY_LOW) begin
                    cipher_key[63:0] = i_cfg_data;
                end else if (i_cfg_index == CFG_KEY_HIGH) begin
                    cipher_key[79:64] = i_cfg_data[15:0];
                end
            end
            // Each accepted plaintext request yields one expected ciphertext.
            if (i_s_tvalid && i_s_tready) begin
                expected_ct.push_back(present80_encrypt(i_s_tdata, cipher_key));
            end
            // Results must come back in request order.
            if (i_m_tvalid && i_m_tready) begin
                if (expected_ct.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: unexpected ciphertext: expected none actual %h",
                             $time, i_m_tdata);
                end else begin
                    want_ct = expected_ct.pop_front();
                    if (i_m_tdata !== want_ct) begin
                        fail_cnt++;
                        $display("%0t: ciphertext mismatch: expected %h actual %h",
                                 $time, want_ct, i_m_tdata);
                    end
                end
            end
        end
        o_fail_count <= fail_cnt;
        o_pending <= expected_ct.size();
    end

endmodule

// File: tb/sv/tb.sv
// Top of the PRESENT-80 encrypt core testbench: clock, reset, key writes,
// plaintext stimulus, output back-pressure, watchdog and verdict.
// Depends on prs80_pkg, present80_block_encrypt_core and prs80_cipher_checker.

module tb
    import prs80_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROUNDS = 31;
    localparam int N_PHASES = 14;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 2 * (ROUNDS + 1);

    // Indexes that decode to no register.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE3 = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0]          i_cfg_data = '0;
    logic                 i_s_tvalid = 1'b0;
    logic [63:0]          i_s_tdata = '0;
    logic                 i_m_tready = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_s_tready;
    logic                 o_m_tvalid;
    logic [63:0]          o_m_tdata;

    int fail_count;
    int pending;
    int stall_cnt = 0;
    int n_blocks = 0;
    int n_key_writes = 0;
    int n_phase_items;
    bit src_idle_en = 1'b1;
    bit snk_idle_en = 1'b1;
    bit hold_req = 1'b0;

    present80_block_encrypt_core #(
        .ROUNDS(ROUNDS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    prs80_cipher_checker #(
        .ROUNDS(ROUNDS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: ends the run after too many cycles without any handshake.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_cfg_valid && o_cfg_ready) || (i_s_tvalid && o_s_tready) ||
                (o_m_tvalid && i_m_tready)) begin
                stall_cnt <= 0;
            end else if (stall_cnt >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, stall_cnt);
                $display("DONE: errors detected");
                $finish;
            end else begin
                stall_cnt <= stall_cnt + 1;
            end
        end
    end

    // Output back-pressure: random stalls, or a long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_m_tready <= !snk_idle_en || ($urandom_range(99) >= 28);
            end
        end
    end

    // Random 64-bit word biased toward the extremes and single bits.
    function automatic logic [63:0] rand_word64();
        logic [63:0] w;
        case ($urandom_range(9))
            0: w = '0;
            1: w = '1;
            2: w = 64'd1 << $urandom_range(63);
            3: w = ~(64'd1 << $urandom_range(63));
            default: w = {$urandom, $urandom};
        endcase
        return w;
    endfunction

    // Raises the key channel and waits for the request to be taken; the
    // caller lowers valid after its last write.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        n_key_writes++;
    endtask

    // Offers one plaintext block, sometimes after a short gap.
    task automatic send_block(input logic [63:0] blk);
        if (src_idle_en && $urandom_range(99) < 28) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= blk;
        do @(posedge i_clk); while (!o_s_tready);
        n_blocks++;
    endtask

    // Stops offering and waits until every ciphertext is back.
    task automatic wait_all_ciphertexts();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset key of zero, including the all-zero known-answer block.
        send_block(64'h0);
        send_block('1);
        send_block(64'h0123_4567_89ab_cdef);
        send_block(64'h8000_0000_0000_0001);
        wait_all_ciphertexts();

        // All-ones key; key_high written with its upper bits set.
        cfg_write(CFG_KEY_LOW, '1);
        cfg_write(CFG_KEY_HIGH, '1);
        i_cfg_valid <= 1'b0;
        send_block(64'h0);
        send_block('1);
        send_block(64'h5555_5555_5555_5555);
        send_block(64'haaaa_aaaa_aaaa_aaaa);
        wait_all_ciphertexts();

        // Writes to unused indexes must leave the key unchanged.
        cfg_write(CFG_IDX_SPARE2, {$urandom, $urandom});
        cfg_write(CFG_IDX_SPARE3, '1);
        i_cfg_valid <= 1'b0;
        send_block(64'h0);
        send_block(64'h0123_4567_89ab_cdef);
        wait_all_ciphertexts();

        // Only the low 16 bits of key_high count; the same block repeated
        // under one key must give the same ciphertext each time.
        cfg_write(CFG_KEY_HIGH, 64'hdead_beef_cafe_0000);
        cfg_write(CFG_KEY_LOW, 64'hfedc_ba98_7654_3210);
        i_cfg_valid <= 1'b0;
        repeat (3) send_block(64'h1357_9bdf_0246_8ace);
        send_block(64'hffff_0000_ffff_0000);
        wait_all_ciphertexts();

        // Random phases, each with its own key setting and traffic shape.
        for (int p = 0; p < N_PHASES; p++) begin
            if (p == 0) begin
                cfg_write(CFG_KEY_LOW, '0);
                cfg_write(CFG_KEY_HIGH, '0);
            end else if (p == N_PHASES - 1) begin
                cfg_write(CFG_KEY_LOW, '1);
                cfg_write(CFG_KEY_HIGH, '1);
            end else begin
                case (p % 4)
                    0: begin
                        cfg_write(CFG_KEY_LOW, rand_word64());
                        cfg_write(CFG_KEY_HIGH, rand_word64());
                    end
                    1: cfg_write(CFG_KEY_LOW, rand_word64());
                    2: cfg_write(CFG_KEY_HIGH, rand_word64());
                    default: begin
                        cfg_write($urandom_range(1) ? CFG_IDX_SPARE2 : CFG_IDX_SPARE3,
                                  rand_word64());
                        cfg_write(CFG_KEY_HIGH, rand_word64());
                        cfg_write(CFG_KEY_LOW, rand_word64());
                    end
                endcase
            end
            i_cfg_valid <= 1'b0;

            // One phase runs with no gaps at all; two hold off the output
            // long enough for the pipeline to fill and stall its input.
            src_idle_en = (p != 3);
            snk_idle_en = (p != 3);
            if (p == 5 || p == 10) begin
                hold_req = 1'b1;
            end
            n_phase_items = $urandom_range(60, 95);
            repeat (n_phase_items) send_block(rand_word64());
            wait_all_ciphertexts();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Run covered %0d blocks over %0d key register writes, with unused",
                 n_blocks, n_key_writes);
        $display("indexes, wide key_high values, full-pipeline hold-offs and gap-free traffic.");
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
